// ===== design/tsq_pkg.sv =====
// Package for the touch sample qualifier: field widths, register indexes,
// request, result, command and status types. No dependencies.
package tsq_pkg;

  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned SCREEN_W  = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ORIENT_W  = 3;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned SETTLE_W  = 4;
  localparam int unsigned ATTEMPT_W = 3;
  localparam int unsigned PROD_W    = 2 * SAMPLE_W;
  localparam int unsigned VAL_W     = PROD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_SPAN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SPAN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd6;

  localparam logic CMD_PRESSURE = 1'b0;
  localparam logic CMD_POSITION = 1'b1;

  localparam int unsigned ORIENT_SWAP  = 0;
  localparam int unsigned ORIENT_INV_X = 1;
  localparam int unsigned ORIENT_INV_Y = 2;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
  } tsq_req_t;

  typedef struct packed {
    logic                want_position;
    logic                poll_done;
    logic                pressed;
    logic [SCREEN_W-1:0] point_x;
    logic [SCREEN_W-1:0] point_y;
  } tsq_res_t;

  typedef struct packed {
    logic step;
    logic sel_y;
    logic mul;
    logic div_start;
    logic fin;
    logic push;
  } tsq_cmd_t;

  typedef struct packed {
    logic cal_needed;
    logic div_done;
  } tsq_sts_t;

endpackage

// ===== design/touch_sample_qualifier.sv =====
// Touch sample qualifier: judges pressure and position samples from a
// resistive touch controller, one request at a time, and returns one result
// per request naming the next sample kind, plus the calibrated touch point at
// the end of each poll. A request that does not finish a poll with a found
// touch goes from evaluation straight to the output register; one that does
// is first calibrated on the shared bit-serial divider (24 quotient bits per
// axis, x then y). A finished result sits in the output register, so the next
// request is taken while it waits. Configuration writes land at once; the user
// must make them only while the block is idle; this is not enforced.
// Depends on tsq_pkg, tsq_ctrl, tsq_dp and tsq_div.
module touch_sample_qualifier #(
  parameter int unsigned SETTLE_READS  = 8,
  parameter int unsigned ATTEMPTS      = 5,
  parameter int unsigned SCREEN_WIDTH  = 480,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tsq_pkg::tsq_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tsq_pkg::tsq_res_t             out_res_o,
  input  logic                          cfg_we_i,
  input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsq_pkg::SAMPLE_W-1:0]  cfg_data_i
);
  import tsq_pkg::*;

  tsq_cmd_t cmd;
  tsq_sts_t sts;

  tsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tsq_dp #(
    .SETTLE_READS  (SETTLE_READS),
    .ATTEMPTS      (ATTEMPTS),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (out_res_o)
  );

endmodule

// ===== design/tsq_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tsq_pkg for the operand widths.
module tsq_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsq_pkg::PROD_W-1:0]   dividend_i,
  input  logic [tsq_pkg::SAMPLE_W-1:0] divisor_i,
  output logic [tsq_pkg::PROD_W-1:0]   quotient_o,
  output logic                         done_o
);
  import tsq_pkg::*;

  localparam int unsigned CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(PROD_W - 1);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [SAMPLE_W-1:0] div_q;
  logic [PROD_W-1:0]   quo_q;
  logic [SAMPLE_W:0]   trial;
  logic                bit_d;

  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = SAMPLE_W'(trial - {1'b0, div_q});
      bit_d = 1'b1;
    end else begin
      rem_d = trial[SAMPLE_W-1:0];
      bit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_C) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[PROD_W-2:0], bit_d};
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== design/tsq_dp.sv =====
// Datapath: configuration registers, sample qualification state, calibration
// arithmetic and the result register. Depends on tsq_pkg and tsq_div.
module tsq_dp #(
  parameter int unsigned SETTLE_READS  = 8,
  parameter int unsigned ATTEMPTS      = 5,
  parameter int unsigned SCREEN_WIDTH  = 480,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsq_pkg::tsq_req_t             req_i,
  input  logic                          cfg_we_i,
  input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tsq_pkg::SAMPLE_W-1:0]  cfg_data_i,
  input  tsq_pkg::tsq_cmd_t             cmd_i,
  output tsq_pkg::tsq_sts_t             sts_o,
  output tsq_pkg::tsq_res_t             res_o
);
  import tsq_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_SETTLE,
    PH_POS1,
    PH_RECHECK,
    PH_POS2
  } phase_e;

  localparam logic [SAMPLE_W-1:0]  WIDTH_C  = SAMPLE_W'(SCREEN_WIDTH);
  localparam logic [SAMPLE_W-1:0]  HEIGHT_C = SAMPLE_W'(SCREEN_HEIGHT);
  localparam logic [SETTLE_W-1:0]  SETTLE_C = SETTLE_W'(SETTLE_READS);
  localparam logic [ATTEMPT_W-1:0] ATTEMPT_C = ATTEMPT_W'(ATTEMPTS);
  localparam logic [SAMPLE_W-1:0]  FULL_C   = {SAMPLE_W{1'b1}};
  localparam logic [SAMPLE_W-1:0]  PREV_RST = SAMPLE_W'(1);

  function automatic logic [SAMPLE_W-1:0] pressure_of(input logic [SAMPLE_W-1:0] z1,
                                                      input logic [SAMPLE_W-1:0] z2);
    logic [SAMPLE_W:0] z;
    z = {1'b0, FULL_C} + {1'b0, z1} - {1'b0, z2};
    if (z == {1'b0, FULL_C}) begin
      return '0;
    end else if (z[SAMPLE_W]) begin
      return FULL_C;
    end
    return z[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] diff_of(input logic [SAMPLE_W-1:0] p,
                                                  input logic [SAMPLE_W-1:0] q);
    return (p > q) ? p - q : q - p;
  endfunction

  // configuration
  logic [SAMPLE_W-1:0] thr_q, delta_q, xoff_q, xspan_q, yoff_q, yspan_q;
  logic [ORIENT_W-1:0] orient_q;

  // qualification state
  phase_e               phase_q, phase_d;
  logic [SAMPLE_W-1:0]  prev_q, prev_d;
  logic [SETTLE_W-1:0]  settle_q, settle_d;
  logic [ATTEMPT_W-1:0] attempt_q, attempt_d, attempt_inc;
  logic [SAMPLE_W-1:0]  first_x_q, first_x_d, first_y_q, first_y_d;
  logic [SAMPLE_W-1:0]  kept_x_q, kept_x_d, kept_y_q, kept_y_d;
  logic                 found_q, found_d;
  logic [SAMPLE_W-1:0]  kx_upd, ky_upd;
  logic                 found_upd;
  logic                 kind_ok, end_att, done, wants_pos;
  logic [SAMPLE_W-1:0]  z;

  // per-request result and calibration
  logic                want_q, done_q, cal_q;
  logic [SAMPLE_W-1:0] rx_q, ry_q;
  logic [PROD_W-1:0]   mag_q;
  logic                neg_q;
  logic [SCREEN_W-1:0] sx_q, sy_q;
  logic                okx_q, oky_q;
  tsq_res_t            res_q;

  logic [SAMPLE_W-1:0] raw, off, span, span_eff, size;
  logic                inv, neg;
  logic [SAMPLE_W-1:0] absd;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   quo;
  logic                div_done;
  logic signed [VAL_W-1:0] qs, val, size_s;
  logic                ok;
  logic                pressed;

  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    settle_d  = settle_q;
    attempt_d = attempt_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    kx_upd    = kept_x_q;
    ky_upd    = kept_y_q;
    found_upd = found_q;
    end_att   = 1'b0;
    done      = 1'b0;
    wants_pos = (phase_q == PH_POS1) || (phase_q == PH_POS2);
    kind_ok   = ((req_i.cmd == CMD_POSITION) == wants_pos);
    z         = pressure_of(req_i.sample_a, req_i.sample_b);
    attempt_inc = attempt_q + 1'b1;

    if (kind_ok) begin
      case (phase_q)
        PH_SETTLE: begin
          if (z <= prev_q) begin
            if (z > thr_q) phase_d = PH_POS1;
            else           end_att = 1'b1;
          end else begin
            prev_d   = z;
            settle_d = settle_q + 1'b1;
            if (settle_d >= SETTLE_C) end_att = 1'b1;
          end
        end
        PH_POS1: begin
          first_x_d = req_i.sample_a;
          first_y_d = req_i.sample_b;
          phase_d   = PH_RECHECK;
        end
        PH_RECHECK: begin
          if (z > thr_q) phase_d = PH_POS2;
          else           end_att = 1'b1;
        end
        PH_POS2: begin
          if (diff_of(first_x_q, req_i.sample_a) <= delta_q &&
              diff_of(first_y_q, req_i.sample_b) <= delta_q) begin
            kx_upd    = first_x_q;
            ky_upd    = first_y_q;
            found_upd = 1'b1;
          end
          end_att = 1'b1;
        end
        default: phase_d = PH_SETTLE;
      endcase
    end

    if (end_att) begin
      phase_d   = PH_SETTLE;
      prev_d    = PREV_RST;
      settle_d  = '0;
      attempt_d = attempt_inc;
      done      = (attempt_inc >= ATTEMPT_C);
    end

    kept_x_d = kx_upd;
    kept_y_d = ky_upd;
    found_d  = found_upd;
    if (done) begin
      attempt_d = '0;
      found_d   = 1'b0;
      kept_x_d  = '0;
      kept_y_d  = '0;
    end
  end

  // axis selection for the shared multiplier and divider
  always_comb begin
    raw  = cmd_i.sel_y ? ry_q     : rx_q;
    off  = cmd_i.sel_y ? yoff_q   : xoff_q;
    span = cmd_i.sel_y ? yspan_q  : xspan_q;
    size = cmd_i.sel_y ? HEIGHT_C : WIDTH_C;
    inv  = cmd_i.sel_y ? orient_q[ORIENT_INV_Y] : orient_q[ORIENT_INV_X];
    span_eff = (span == '0) ? SAMPLE_W'(1) : span;
    neg  = (raw < off);
    absd = neg ? off - raw : raw - off;
    prod = PROD_W'(absd * size);
    size_s = $signed({{(VAL_W-SAMPLE_W){1'b0}}, size});
    qs   = $signed({2'b00, quo});
    if (neg_q) qs = -qs;
    val  = inv ? size_s - qs : qs;
    ok   = (val >= 0) && (val < size_s);
    pressed = cal_q && okx_q && oky_q;
  end

  tsq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_q),
    .divisor_i  (span_eff),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= 12'd20;
      delta_q   <= 12'd20;
      xoff_q    <= 12'd248;
      xspan_q   <= 12'd3571;
      yoff_q    <= 12'd202;
      yspan_q   <= 12'd3647;
      orient_q  <= 3'd5;
      phase_q   <= PH_SETTLE;
      prev_q    <= PREV_RST;
      settle_q  <= '0;
      attempt_q <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      kept_x_q  <= '0;
      kept_y_q  <= '0;
      found_q   <= 1'b0;
      want_q    <= 1'b0;
      done_q    <= 1'b0;
      cal_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD:   thr_q    <= cfg_data_i;
          REG_DELTA:       delta_q  <= cfg_data_i;
          REG_X_OFFSET:    xoff_q   <= cfg_data_i;
          REG_X_SPAN:      xspan_q  <= cfg_data_i;
          REG_Y_OFFSET:    yoff_q   <= cfg_data_i;
          REG_Y_SPAN:      yspan_q  <= cfg_data_i;
          REG_ORIENTATION: orient_q <= cfg_data_i[ORIENT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.step) begin
        phase_q   <= phase_d;
        prev_q    <= prev_d;
        settle_q  <= settle_d;
        attempt_q <= attempt_d;
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        kept_x_q  <= kept_x_d;
        kept_y_q  <= kept_y_d;
        found_q   <= found_d;
        want_q    <= (phase_d == PH_POS1) || (phase_d == PH_POS2);
        done_q    <= done;
        cal_q     <= done && found_upd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rx_q <= orient_q[ORIENT_SWAP] ? ky_upd : kx_upd;
      ry_q <= orient_q[ORIENT_SWAP] ? kx_upd : ky_upd;
    end
    if (cmd_i.mul) begin
      mag_q <= prod;
      neg_q <= neg;
    end
    if (cmd_i.fin) begin
      if (cmd_i.sel_y) begin
        sy_q  <= val[SCREEN_W-1:0];
        oky_q <= ok;
      end else begin
        sx_q  <= val[SCREEN_W-1:0];
        okx_q <= ok;
      end
    end
    if (cmd_i.push) begin
      res_q.want_position <= want_q;
      res_q.poll_done     <= done_q;
      res_q.pressed       <= pressed;
      res_q.point_x       <= pressed ? sx_q : '0;
      res_q.point_y       <= pressed ? sy_q : '0;
    end
  end

  assign sts_o.cal_needed = cal_q;
  assign sts_o.div_done   = div_done;
  assign res_o            = res_q;

endmodule

// ===== design/tsq_ctrl.sv =====
// Controller: sequences request evaluation, calibration and result hand-off.
// Depends on tsq_pkg for the command and status types.
module tsq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  input  tsq_pkg::tsq_sts_t sts_i,
  output tsq_pkg::tsq_cmd_t cmd_o
);
  import tsq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_X,
    ST_DIV_X,
    ST_WAIT_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_PUSH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.step      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sel_y     = (state_q == ST_MUL_Y) || (state_q == ST_DIV_Y) ||
                      (state_q == ST_WAIT_Y);
    cmd_o.mul       = (state_q == ST_MUL_X) || (state_q == ST_MUL_Y);
    cmd_o.div_start = (state_q == ST_DIV_X) || (state_q == ST_DIV_Y);
    cmd_o.fin       = ((state_q == ST_WAIT_X) || (state_q == ST_WAIT_Y)) && sts_i.div_done;
    cmd_o.push      = (state_q == ST_PUSH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_EVAL;
        ST_EVAL:   state_q <= sts_i.cal_needed ? ST_MUL_X : ST_PUSH;
        ST_MUL_X:  state_q <= ST_DIV_X;
        ST_DIV_X:  state_q <= ST_WAIT_X;
        ST_WAIT_X: if (sts_i.div_done) state_q <= ST_MUL_Y;
        ST_MUL_Y:  state_q <= ST_DIV_Y;
        ST_DIV_Y:  state_q <= ST_WAIT_Y;
        ST_WAIT_Y: if (sts_i.div_done) state_q <= ST_PUSH;
        ST_PUSH:   if (out_free) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
